[hdl/fcsb_pkg.sv]
// ----------------------------------------------------------------------------
// fcsb_pkg: shared types and constants
// Plane register layout, configuration indexes and the volume record that
// travels from the input register into the plane lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsb_pkg;

    // Number of plane registers and the planes kept in ignore-depth mode
    localparam int PLANE_REGS        = 6;
    localparam int DEPTH_FREE_PLANES = 4;

    // Normals are Q1.14; d and radius are scaled up by this many bits
    localparam int NORMAL_FRAC = 14;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes (planes 0..5 use their own number)
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_DEPTH = 3'd6;

    // Volume kinds
    localparam logic OP_SPHERE = 1'b0;
    localparam logic OP_BOX    = 1'b1;

    typedef logic [CFG_DATA_W-1:0] t_plane_word;

    typedef struct packed {
        logic               is_box;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic        [14:0] radius;
    } t_volume;

endpackage : fcsb_pkg

`default_nettype wire

[hdl/fcsb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fcsb_cfg_regs: plane and mode registers
// Holds the packed frustum planes and the ignore-depth flag, written through
// a plain write port. Writes to an index past the list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsb_cfg_regs
    import fcsb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_plane_word               o_plane_word [PLANE_REGS],
    output logic                      o_ignore_depth
);

    t_plane_word r_plane_word [PLANE_REGS];
    logic        r_ignore_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PLANE_REGS; i++) begin
                r_plane_word[i] <= '0;
            end
            r_ignore_depth <= 1'b0;
        end else if (i_cfg_we) begin
            for (int i = 0; i < PLANE_REGS; i++) begin
                if (i_cfg_index == CFG_IDX_W'(i)) begin
                    r_plane_word[i] <= i_cfg_data;
                end
            end
            if (i_cfg_index == CFG_IGNORE_DEPTH) begin
                r_ignore_depth <= i_cfg_data[0];
            end
        end
    end

    assign o_plane_word   = r_plane_word;
    assign o_ignore_depth = r_ignore_depth;

endmodule : fcsb_cfg_regs

`default_nettype wire

[hdl/fcsb_plane_lane.sv]
// ----------------------------------------------------------------------------
// fcsb_plane_lane: one plane test
// Forms the three normal products (positive vertex for boxes), registers
// them with the bias, then scales the bias, sums and compares against zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsb_plane_lane
    import fcsb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire t_plane_word i_plane_word,
    input  wire t_volume     i_volume,
    output logic            o_culled
);

    localparam int PROD_W = 32;
    localparam int BIAS_W = 17;
    localparam int SUM_W  = 34;

    logic signed [15:0]       w_n    [3];
    logic signed [15:0]       w_a    [3];
    logic signed [15:0]       w_b    [3];
    logic signed [PROD_W-1:0] w_pa   [3];
    logic signed [PROD_W-1:0] w_pb   [3];
    logic signed [PROD_W-1:0] n_term [3];
    logic signed [BIAS_W-1:0] n_bias;
    logic signed [PROD_W-1:0] r_term [3];
    logic signed [BIAS_W-1:0] r_bias;
    logic signed [SUM_W-1:0]  w_sum;

    always_comb begin
        w_n[0] = $signed(i_plane_word[15:0]);
        w_n[1] = $signed(i_plane_word[31:16]);
        w_n[2] = $signed(i_plane_word[47:32]);
        w_a[0] = i_volume.a_x;
        w_a[1] = i_volume.a_y;
        w_a[2] = i_volume.a_z;
        w_b[0] = i_volume.b_x;
        w_b[1] = i_volume.b_y;
        w_b[2] = i_volume.b_z;
        for (int k = 0; k < 3; k++) begin
            w_pa[k] = w_n[k] * w_a[k];
            w_pb[k] = w_n[k] * w_b[k];
            // positive vertex: take the larger product on each axis
            if (i_volume.is_box == OP_BOX && w_pb[k] > w_pa[k]) begin
                n_term[k] = w_pb[k];
            end else begin
                n_term[k] = w_pa[k];
            end
        end
        // sphere: n.c + d + r <= 0; box: positive vertex + d <= 0
        n_bias = BIAS_W'($signed(i_plane_word[63:48]));
        if (i_volume.is_box == OP_SPHERE) begin
            n_bias = n_bias + $signed({2'b00, i_volume.radius});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= n_term;
            r_bias <= n_bias;
        end
    end

    always_comb begin
        w_sum = SUM_W'(r_term[0]) + SUM_W'(r_term[1]) + SUM_W'(r_term[2])
              + (SUM_W'(r_bias) <<< NORMAL_FRAC);
        o_culled = (w_sum <= 0);
    end

endmodule : fcsb_plane_lane

`default_nettype wire

[hdl/frustum_cull_sphere_box.sv]
// ----------------------------------------------------------------------------
// frustum_cull_sphere_box: sphere / box frustum culling
// Tests one bounding volume per item against the stored frustum planes.
// ----------------------------------------------------------------------------
// Usage:
//   Load the planes through the write port (index 0..5 one packed plane
//   each: nx, ny, nz Q1.14 in bits 0-47, d in bits 48-63; index 6 the
//   ignore-depth flag in bit 0). Write only while no item is in flight.
//   Send volumes on the input channel (i_valid / o_ready): operation 0 is
//   a sphere (center a, radius), operation 1 a box (min a, max b).
//   Each item gives one result on the output channel (o_valid / i_ready):
//   culled, and the batch-end mark copied through.
// Timing:
//   Three register stages: input register, product register (one 16x16
//   multiplier pair per axis per plane), result register. o_valid rises when
//   an accepted item reaches the result register; one item per cycle is
//   sustained while i_ready is high. On a receiver stall the pipeline
//   closes up from the output back; o_ready drops only once every stage holds an item.
// Reset:
//   Synchronous, active low. Clears all stage valids and the plane
//   registers; an all-zero plane culls every box and zero-radius spheres.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_cull_sphere_box
    import fcsb_pkg::*;
#(
    parameter int PLANE_COUNT = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_operation,
    input  wire logic signed [15:0]    i_a_x,
    input  wire logic signed [15:0]    i_a_y,
    input  wire logic signed [15:0]    i_a_z,
    input  wire logic signed [15:0]    i_b_x,
    input  wire logic signed [15:0]    i_b_y,
    input  wire logic signed [15:0]    i_b_z,
    input  wire logic [14:0]           i_radius,
    input  wire logic                  i_batch_end_in,
    // output channel
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_culled,
    output logic                       o_batch_end_out
);

    // Only six plane registers exist; extra planes add nothing
    localparam int LANES = (PLANE_COUNT < PLANE_REGS) ? PLANE_COUNT : PLANE_REGS;

    t_plane_word w_plane_word [PLANE_REGS];
    logic        w_ignore_depth;

    // Pipeline state
    logic        r_s1_valid;
    t_volume     r_s1_volume;
    logic        r_s1_batch_end;
    logic        r_s2_valid;
    logic        r_s2_batch_end;
    logic        r_out_valid;
    logic        r_out_culled;
    logic        r_out_batch_end;

    logic        w_out_en;
    logic        w_s2_en;
    logic        w_s1_en;
    logic [LANES-1:0] w_lane_culled;
    logic [LANES-1:0] w_lane_active;
    logic        n_culled;

    fcsb_cfg_regs u_cfg_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_plane_word   (w_plane_word),
        .o_ignore_depth (w_ignore_depth)
    );

    // Each stage advances when the one after it is empty or advancing
    assign w_out_en = !r_out_valid || i_ready;
    assign w_s2_en  = !r_s2_valid  || w_out_en;
    assign w_s1_en  = !r_s1_valid  || w_s2_en;
    assign o_ready  = w_s1_en;

    // Stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_en && i_valid) begin
            r_s1_volume.is_box <= i_operation;
            r_s1_volume.a_x    <= i_a_x;
            r_s1_volume.a_y    <= i_a_y;
            r_s1_volume.a_z    <= i_a_z;
            r_s1_volume.b_x    <= i_b_x;
            r_s1_volume.b_y    <= i_b_y;
            r_s1_volume.b_z    <= i_b_z;
            r_s1_volume.radius <= i_radius;
            r_s1_batch_end     <= i_batch_end_in;
        end
    end

    // Stage 2: per-plane products, registered inside each lane
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        fcsb_plane_lane u_lane (
            .i_clk        (i_clk),
            .i_en         (w_s2_en),
            .i_plane_word (w_plane_word[g]),
            .i_volume     (r_s1_volume),
            .o_culled     (w_lane_culled[g])
        );
        // Drop the depth planes in ignore-depth mode
        assign w_lane_active[g] = !w_ignore_depth || (g < DEPTH_FREE_PLANES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_en) begin
            r_s2_batch_end <= r_s1_batch_end;
        end
    end

    // Stage 3: sum, compare and combine the active planes
    assign n_culled = |(w_lane_culled & w_lane_active);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_out_culled    <= n_culled;
            r_out_batch_end <= r_s2_batch_end;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_culled        = r_out_culled;
    assign o_batch_end_out = r_out_batch_end;

endmodule : frustum_cull_sphere_box

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: frustum_cull_sphere_box
// Drives spheres and boxes through the culling block under several plane
// settings and flow-control patterns. A scoreboard recomputes the cull flag
// of every accepted item from its own copy of the planes and checks each
// result in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fcsb_pkg::*;

    localparam int     PLANES_USED     = 6;
    localparam longint Q_SCALE         = longint'(1) << NORMAL_FRAC;
    localparam int     Q_ONE           = 1 << NORMAL_FRAC;
    // Index past the last register: a write here must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam int     SETTLE_CYCLES   = 8;
    localparam int     STUCK_LIMIT     = 4000;
    localparam int     PHASES          = 8;
    localparam int     PHASE_ITEMS     = 100;
    localparam int     PRESSURE_CYCLES = 80;

    typedef struct {
        bit culled;
        bit batch_end;
    } t_cull_expect;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the plane registers, cull predictor and the
    // queue of expected results in acceptance order.
    // ------------------------------------------------------------------------
    class cull_scoreboard;
        bit [CFG_DATA_W-1:0] planes [PLANE_REGS];
        bit                  skip_depth;
        t_cull_expect        pending [$];
        int                  errors;
        int                  volumes_seen;
        int                  boxes_seen;
        int                  culled_seen;

        // Mirror a register write; unknown indexes are dropped
        function void write_reg(logic [CFG_IDX_W-1:0] idx, t_plane_word data);
            if (idx < PLANE_REGS)
                planes[idx] = data;
            else if (idx == CFG_IGNORE_DEPTH)
                skip_depth = data[0];
        endfunction

        function longint widen(logic [15:0] w);
            logic signed [15:0] s;
            s = w;
            return s;
        endfunction

        // Scale everything by 2^14 and compare exactly against the plane
        function bit volume_culled(t_volume v);
            longint lo [3];
            longint hi [3];
            longint nrm [3];
            longint plane_dist;
            longint p_lo;
            longint p_hi;
            longint r_scaled;
            int     active;
            bit     hit;
            lo[0] = widen(v.a_x);
            lo[1] = widen(v.a_y);
            lo[2] = widen(v.a_z);
            hi[0] = widen(v.b_x);
            hi[1] = widen(v.b_y);
            hi[2] = widen(v.b_z);
            r_scaled = longint'(v.radius) * Q_SCALE;
            active = skip_depth ? DEPTH_FREE_PLANES : PLANE_REGS;
            if (active > PLANES_USED)
                active = PLANES_USED;
            hit = 1'b0;
            for (int p = 0; p < active; p++) begin
                for (int k = 0; k < 3; k++)
                    nrm[k] = widen(planes[p][16*k +: 16]);
                plane_dist = widen(planes[p][63:48]) * Q_SCALE;
                for (int k = 0; k < 3; k++) begin
                    if (v.is_box == OP_BOX) begin
                        // positive vertex: take the larger product per axis
                        p_lo = nrm[k] * lo[k];
                        p_hi = nrm[k] * hi[k];
                        plane_dist += (p_lo > p_hi) ? p_lo : p_hi;
                    end else begin
                        plane_dist += nrm[k] * lo[k];
                    end
                end
                if (v.is_box == OP_BOX)
                    hit |= (plane_dist <= 0);
                else
                    hit |= (plane_dist <= -r_scaled);
            end
            return hit;
        endfunction

        function void note_volume(t_volume v, bit last);
            t_cull_expect e;
            e.culled    = volume_culled(v);
            e.batch_end = last;
            pending.push_back(e);
            volumes_seen++;
            if (v.is_box == OP_BOX)
                boxes_seen++;
            if (e.culled)
                culled_seen++;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(bit culled, bit last);
            t_cull_expect e;
            if (pending.size() == 0) begin
                report_mismatch("result arrived with no volume outstanding");
            end else begin
                e = pending.pop_front();
                if (culled !== e.culled)
                    report_mismatch($sformatf("culled %0b, expected %0b",
                                              culled, e.culled));
                if (last !== e.batch_end)
                    report_mismatch($sformatf("batch_end_out %0b, expected %0b",
                                              last, e.batch_end));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_operation;
    logic signed [15:0]    i_a_x;
    logic signed [15:0]    i_a_y;
    logic signed [15:0]    i_a_z;
    logic signed [15:0]    i_b_x;
    logic signed [15:0]    i_b_y;
    logic signed [15:0]    i_b_z;
    logic [14:0]           i_radius;
    logic                  i_batch_end_in;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_culled;
    logic                  o_batch_end_out;

    frustum_cull_sphere_box #(
        .PLANE_COUNT(PLANES_USED)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_a_x          (i_a_x),
        .i_a_y          (i_a_y),
        .i_a_z          (i_a_z),
        .i_b_x          (i_b_x),
        .i_b_y          (i_b_y),
        .i_b_z          (i_b_z),
        .i_radius       (i_radius),
        .i_batch_end_in (i_batch_end_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_culled       (o_culled),
        .o_batch_end_out(o_batch_end_out)
    );

    cull_scoreboard sb = new;

    // Flow-control knobs, set per phase by the main sequence
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int span           = 1000;  // scale of "interesting" coordinates
    int settings_used  = 0;
    int stuck_cycles   = 0;
    t_volume seen;

    always #4 i_clk = ~i_clk;

    // Receiver: stall at random, or hold off for a counted stretch when asked
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready = 1'b0;
            hold_left--;
        end else begin
            i_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Sample both channels at the rising edge; note the input before checking
    // the output so a combinational input-to-output path would still line up.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                seen.is_box = i_operation;
                seen.a_x    = i_a_x;
                seen.a_y    = i_a_y;
                seen.a_z    = i_a_z;
                seen.b_x    = i_b_x;
                seen.b_y    = i_b_y;
                seen.b_z    = i_b_z;
                seen.radius = i_radius;
                sb.note_volume(seen, i_batch_end_in);
            end
            if (o_valid && i_ready)
                sb.check_result(o_culled, o_batch_end_out);
        end
    end

    // Watchdog: too long without any item moving on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("[%0t] watchdog: no item moved for %0d cycles, %0d pending",
                             $realtime, STUCK_LIMIT, sb.pending.size());
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks (called and returning at a falling edge)
    // ------------------------------------------------------------------------
    task automatic offer_volume(input t_volume v, input bit last);
        // idle gap before this item
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_operation    = v.is_box;
        i_a_x          = v.a_x;
        i_a_y          = v.a_y;
        i_a_z          = v.a_z;
        i_b_x          = v.b_x;
        i_b_y          = v.b_y;
        i_b_z          = v.b_z;
        i_radius       = v.radius;
        i_batch_end_in = last;
        i_valid        = 1'b1;
        // hold until the block takes the item
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_plane_word data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic drain;
        i_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_planes(input t_plane_word words [PLANE_REGS], input bit skip);
        for (int p = 0; p < PLANE_REGS; p++)
            write_reg(CFG_IDX_W'(p), words[p]);
        write_reg(CFG_IGNORE_DEPTH, CFG_DATA_W'(skip));
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_plane_word pack_plane(int nx, int ny, int nz, int d);
        return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    // Axis-aligned cube |x|,|y|,|z| < k: even planes face +axis, odd face -axis
    function automatic t_plane_word axis_plane(int p, int k);
        int n [3];
        n = '{0, 0, 0};
        n[p / 2] = (p % 2 == 0) ? Q_ONE : -Q_ONE;
        return pack_plane(n[0], n[1], n[2], k);
    endfunction

    function automatic t_volume sphere_at(int x, int y, int z, int r);
        t_volume v;
        v        = '0;
        v.is_box = OP_SPHERE;
        v.a_x    = 16'(x);
        v.a_y    = 16'(y);
        v.a_z    = 16'(z);
        v.radius = 15'(r);
        return v;
    endfunction

    function automatic t_volume box_span(int ax, int ay, int az, int bx, int by, int bz);
        t_volume v;
        v        = '0;
        v.is_box = OP_BOX;
        v.a_x    = 16'(ax);
        v.a_y    = 16'(ay);
        v.a_z    = 16'(az);
        v.b_x    = 16'(bx);
        v.b_y    = 16'(by);
        v.b_z    = 16'(bz);
        return v;
    endfunction

    // Mostly near the frustum, sometimes the extremes or anything at all
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2, 3:    return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 3 * span)) - 3 * span / 2);
        endcase
    endfunction

    function automatic t_volume rand_volume();
        t_volume v;
        v.is_box = 1'($urandom_range(0, 1));
        v.a_x    = rand_coord();
        v.a_y    = rand_coord();
        v.a_z    = rand_coord();
        if ($urandom_range(0, 5) == 0) begin
            // anything goes, min above max included
            v.b_x = 16'($urandom);
            v.b_y = 16'($urandom);
            v.b_z = 16'($urandom);
        end else begin
            v.b_x = v.a_x + 16'($urandom_range(0, span));
            v.b_y = v.a_y + 16'($urandom_range(0, span));
            v.b_z = v.a_z + 16'($urandom_range(0, span));
        end
        case ($urandom_range(0, 7))
            0:       v.radius = '0;
            1:       v.radius = '1;
            2:       v.radius = 15'($urandom);
            default: v.radius = 15'($urandom_range(0, span));
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_plane_word plane_set [PLANE_REGS];
        int          style;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_operation    = OP_SPHERE;
        i_a_x          = '0;
        i_a_y          = '0;
        i_a_z          = '0;
        i_b_x          = '0;
        i_b_y          = '0;
        i_b_z          = '0;
        i_radius       = '0;
        i_batch_end_in = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Planes at reset are all zero: every box is culled, and only
        // spheres of radius zero.
        offer_volume(box_span(0, 0, 0, 0, 0, 0), 1'b0);
        offer_volume(sphere_at(0, 0, 0, 0), 1'b0);
        offer_volume(sphere_at(-32768, -32768, -32768, 32767), 1'b1);
        drain();

        // Cube of half-width 1000; exercise touching and min-above-max cases
        for (int p = 0; p < PLANE_REGS; p++)
            plane_set[p] = axis_plane(p, 1000);
        load_planes(plane_set, 1'b0);
        offer_volume(sphere_at(0, 0, 0, 0), 1'b0);
        offer_volume(sphere_at(1005, 0, 0, 5), 1'b0);       // just touches outside
        offer_volume(sphere_at(1004, 0, 0, 5), 1'b0);
        offer_volume(sphere_at(-1010, 0, 0, 9), 1'b1);
        offer_volume(box_span(1000, 0, 0, 1200, 10, 10), 1'b0);   // face on the plane
        offer_volume(box_span(999, 0, 0, 1200, 10, 10), 1'b0);
        offer_volume(box_span(10, 10, 10, -10, -10, -10), 1'b0);  // min above max
        offer_volume(box_span(-1200, 0, 0, -1500, 0, 0), 1'b1);
        offer_volume(sphere_at(0, 0, 5000, 10), 1'b0);      // beyond a depth plane
        offer_volume(box_span(0, 0, 3000, 10, 10, 4000), 1'b0);
        offer_volume(box_span(-32768, -32768, -32768, 32767, 32767, 32767), 1'b0);
        offer_volume(sphere_at(32767, 32767, 32767, 32767), 1'b1);
        drain();

        // Ignore-depth mode: the same two volumes now pass
        write_reg(CFG_IGNORE_DEPTH, CFG_DATA_W'(1));
        offer_volume(sphere_at(0, 0, 5000, 10), 1'b0);
        offer_volume(box_span(0, 0, 3000, 10, 10, 4000), 1'b1);
        drain();

        // Extreme plane words; a write to the unused index must change nothing
        for (int p = 0; p < PLANE_REGS; p++)
            plane_set[p] = pack_plane(-32768, -32768, -32768, 32767);
        load_planes(plane_set, 1'b0);
        write_reg(CFG_IDX_UNUSED, '1);
        offer_volume(sphere_at(32767, 32767, 32767, 32767), 1'b0);
        offer_volume(box_span(-32768, -32768, -32768, 32767, 32767, 32767), 1'b1);
        drain();
        for (int p = 0; p < PLANE_REGS; p++)
            plane_set[p] = pack_plane(32767, 32767, 32767, -32768);
        load_planes(plane_set, 1'b0);
        offer_volume(sphere_at(-32768, -32768, -32768, 0), 1'b0);
        offer_volume(box_span(32767, 32767, 32767, 32767, 32767, 32767), 1'b1);
        drain();
        for (int p = 0; p < PLANE_REGS; p++)
            plane_set[p] = '1;
        load_planes(plane_set, 1'b0);
        offer_volume(box_span(0, 0, 0, 0, 0, 0), 1'b0);
        offer_volume(sphere_at(-5, -5, -5, 0), 1'b1);
        drain();

        // Random phases: rotate plane styles and flow-control patterns
        for (int phase = 0; phase < PHASES; phase++) begin
            span  = $urandom_range(500, 6000);
            style = phase % 3;
            for (int p = 0; p < PLANE_REGS; p++) begin
                case (style)
                    0: plane_set[p] = axis_plane(p, span);
                    1: plane_set[p] = pack_plane(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                                                 int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                                                 int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                                                 int'($urandom_range(0, 2 * span)));
                    default: plane_set[p] = {$urandom, $urandom};
                endcase
            end
            load_planes(plane_set, 1'($urandom_range(0, 1)));

            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // back-pressure: receiver holds off while items keep coming
                    hold_left      = PRESSURE_CYCLES;
                end
                1: begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default: begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_volume(rand_volume(), $urandom_range(0, 3) == 0);
            drain();
        end

        $display("covered %0d volumes (%0d boxes, %0d culled) over %0d plane settings",
                 sb.volumes_seen, sb.boxes_seen, sb.culled_seen, settings_used);
        $display("flow control: free run, sender gaps, receiver stalls, both, long hold-off");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
